// ----- design/rrs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared widths, codes and controller/datapath interface types for the
// round-robin scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

    localparam int FUNC_W    = 2;
    localparam int PID_W     = 8;
    localparam int TIME_W    = 16;
    localparam int CLK_W     = 21;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 96;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 2'd2;

    localparam logic [CLK_W-1:0]  CLOCK_MAX     = 21'h1F_FFFF;
    localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd4;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan_start;
        logic scan_step;
        logic find_take;
        logic pop;
        logic pop_take;
        logic read_cur;
        logic exec;
        logic scan_eval;
        logic finish;
        logic wait_calc;
        logic emit;
        logic emit_done;
    } cmd_t;

    typedef struct packed {
        logic ring_empty;
        logic table_empty;
        logic find_hit;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ----- design/round_robin_scheduler_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_scheduler_unit
// Round-robin scheduler over a loaded process table, one slice per dispatch, or an all-done result when none is left.
// ----------------------------------------------------------------------------
// Clear and load transactions are carried out as they are accepted. A dispatch
// with a non-empty ready ring pops the ring and reads the current entry; the
// arrival scan then walks the table RAMs through their single read port, one
// entry per cycle. A dispatch that finds the ring empty first runs a search
// scan of the same kind up to the first unfinished entry. A result waiting in
// the output register does not hold off new transactions; only the next
// result stalls behind it. Tables need no clearing pass after reset.
module round_robin_scheduler_unit #(
    parameter int MAX_PROCESSES = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [rrs_pkg::TIME_W-1:0]    cfg_wr_data,  // quantum
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // process_id[7:0], arrival_time[23:8], burst_time[39:24]
    input  wire logic [rrs_pkg::S_TDATA_W-1:0] s_tdata,
    // func[1:0]
    input  wire logic [rrs_pkg::FUNC_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // slice_pid[7:0], slice_start[28:8], slice_end[49:29], finished[50],
    // waiting_time[71:51], turnaround_time[92:72], zero[95:93]
    output logic [rrs_pkg::M_TDATA_W-1:0]      m_tdata,
    // all_done[0]
    output logic                               m_tuser
);
    rrs_pkg::cmd_t    cmd;
    rrs_pkg::status_t status;

    rrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .func     (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rrs_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
`default_nettype wire

// ----- design/rrs_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- design/rrs_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_datapath
// Process table, ready ring, schedule clock, slice arithmetic and the
// result register.
// ----------------------------------------------------------------------------
module rrs_datapath #(
    parameter int MAX_PROCESSES = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [rrs_pkg::TIME_W-1:0]     cfg_wr_data,
    input  wire logic [rrs_pkg::S_TDATA_W-1:0]  in_data,
    input  wire rrs_pkg::cmd_t                  cmd,
    output rrs_pkg::status_t                    status,
    input  wire logic                           m_tready,
    output logic                                m_tvalid,
    output logic [rrs_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tuser
);
    localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW = $clog2(MAX_PROCESSES + 1);
    localparam int TW = rrs_pkg::TIME_W;
    localparam int KW = rrs_pkg::CLK_W;
    localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_PROCESSES - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(MAX_PROCESSES);

    logic [TW-1:0]            quantum_reg, quantum_next;
    logic [MAX_PROCESSES-1:0] marks_reg, marks_next;
    logic [IW-1:0]            head_reg, head_next;
    logic [IW-1:0]            tail_reg, tail_next;
    logic [CW-1:0]            fill_reg, fill_next;
    logic [CW-1:0]            loaded_reg, loaded_next;
    logic [KW-1:0]            clock_reg, clock_next;
    logic [CW-1:0]            scan_j_reg, scan_j_next;
    logic [IW-1:0]            scan_jd_reg, scan_jd_next;
    logic                     scan_vld_reg, scan_vld_next;
    logic                     m_valid_reg, m_valid_next;

    logic [IW-1:0]            cur_reg;
    logic [rrs_pkg::PID_W-1:0] pid_reg;
    logic [TW-1:0]            arr_reg;
    logic [TW-1:0]            burst_reg;
    logic [KW-1:0]            start_reg;
    logic                     fin_reg;
    logic [KW-1:0]            turn_reg;
    logic [KW-1:0]            wait_reg;

    logic [rrs_pkg::PID_W-1:0] out_pid_reg;
    logic [KW-1:0]            out_start_reg;
    logic [KW-1:0]            out_end_reg;
    logic                     out_fin_reg;
    logic [KW-1:0]            out_wait_reg;
    logic [KW-1:0]            out_turn_reg;
    logic                     out_done_reg;

    logic [rrs_pkg::S_TDATA_W-1:0] stat_rd;
    logic [TW-1:0]            rem_rd;
    logic [IW-1:0]            ring_rd;
    logic [TW-1:0]            rd_arr;

    logic                     table_free;
    logic                     stat_wr_en;
    logic                     rem_wr_en;
    logic [IW-1:0]            rem_wr_addr;
    logic [TW-1:0]            rem_wr_data;
    logic                     scan_issue;
    logic                     tbl_rd_en;
    logic [IW-1:0]            tbl_rd_addr;
    logic [CW-1:0]            jd_ext;

    logic [TW-1:0]            q_eff;
    logic [TW-1:0]            ex_len;
    logic [TW-1:0]            rem_new;
    logic [KW:0]              clk_sum;
    logic [KW-1:0]            clk_sat;

    logic                     scan_take;
    logic                     push_en;
    logic                     push_ok;
    logic [IW-1:0]            push_val;

    assign rd_arr      = stat_rd[23:8];
    assign table_free  = loaded_reg < DEPTH_CNT;
    assign stat_wr_en  = cmd.load && table_free;
    assign rem_wr_en   = stat_wr_en || cmd.exec;
    assign rem_wr_addr = cmd.exec ? cur_reg : loaded_reg[IW-1:0];
    assign rem_wr_data = cmd.exec ? rem_new : in_data[39:24];

    assign scan_issue  = cmd.scan_step && (scan_j_reg < loaded_reg);
    assign tbl_rd_en   = scan_issue || cmd.read_cur;
    assign tbl_rd_addr = cmd.read_cur ? cur_reg : scan_j_reg[IW-1:0];
    assign jd_ext      = CW'(scan_jd_reg);

    assign q_eff   = (quantum_reg == '0) ? TW'(1) : quantum_reg;
    assign ex_len  = (rem_rd < q_eff) ? rem_rd : q_eff;
    assign rem_new = rem_rd - ex_len;
    assign clk_sum = {1'b0, clock_reg} + (KW + 1)'(ex_len);
    assign clk_sat = clk_sum[KW] ? rrs_pkg::CLOCK_MAX : clk_sum[KW-1:0];

    assign scan_take = cmd.scan_eval && scan_vld_reg && (scan_jd_reg != cur_reg)
                     && (KW'(rd_arr) <= clock_reg) && (rem_rd != '0)
                     && !marks_reg[scan_jd_reg];
    assign push_en   = scan_take || (cmd.finish && !fin_reg);
    assign push_val  = cmd.finish ? cur_reg : scan_jd_reg;
    assign push_ok   = push_en && (fill_reg < DEPTH_CNT);

    rrs_ram #(
        .WIDTH (rrs_pkg::S_TDATA_W),
        .DEPTH (MAX_PROCESSES)
    ) u_stat_ram (
        .aclk    (aclk),
        .wr_en   (stat_wr_en),
        .wr_addr (loaded_reg[IW-1:0]),
        .wr_data (in_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (stat_rd)
    );

    rrs_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_PROCESSES)
    ) u_rem_ram (
        .aclk    (aclk),
        .wr_en   (rem_wr_en),
        .wr_addr (rem_wr_addr),
        .wr_data (rem_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (rem_rd)
    );

    rrs_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_PROCESSES)
    ) u_ring_ram (
        .aclk    (aclk),
        .wr_en   (push_ok),
        .wr_addr (tail_reg),
        .wr_data (push_val),
        .rd_en   (cmd.pop),
        .rd_addr (head_reg),
        .rd_data (ring_rd)
    );

    always_comb begin
        quantum_next  = cfg_wr_en ? cfg_wr_data : quantum_reg;
        marks_next    = marks_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        loaded_next   = loaded_reg;
        clock_next    = clock_reg;
        scan_j_next   = scan_j_reg;
        scan_jd_next  = scan_jd_reg;
        scan_vld_next = scan_vld_reg;

        if (cmd.scan_start) begin
            scan_j_next   = '0;
            scan_vld_next = 1'b0;
        end else if (cmd.scan_step) begin
            scan_vld_next = scan_issue;
            if (scan_issue) begin
                scan_jd_next = scan_j_reg[IW-1:0];
                scan_j_next  = scan_j_reg + CW'(1);
            end
        end

        if (stat_wr_en) begin
            marks_next[loaded_reg[IW-1:0]] = 1'b0;
            loaded_next = loaded_reg + CW'(1);
        end
        if (cmd.find_take) begin
            marks_next[scan_jd_reg] = 1'b1;
            if (KW'(rd_arr) > clock_reg) begin
                clock_next = KW'(rd_arr);
            end
        end
        if (scan_take) begin
            marks_next[scan_jd_reg] = 1'b1;
        end
        if (cmd.exec) begin
            clock_next = clk_sat;
        end

        if (push_ok) begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + IW'(1);
            fill_next = fill_next + CW'(1);
        end
        if (cmd.pop) begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + IW'(1);
            fill_next = fill_next - CW'(1);
        end

        if (cmd.clear) begin
            marks_next  = '0;
            head_next   = '0;
            tail_next   = '0;
            fill_next   = '0;
            loaded_next = '0;
            clock_next  = '0;
        end

        if (cmd.emit || cmd.emit_done) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg  <= rrs_pkg::QUANTUM_RESET;
            marks_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            loaded_reg   <= '0;
            clock_reg    <= '0;
            scan_j_reg   <= '0;
            scan_jd_reg  <= '0;
            scan_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            quantum_reg  <= quantum_next;
            marks_reg    <= marks_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            loaded_reg   <= loaded_next;
            clock_reg    <= clock_next;
            scan_j_reg   <= scan_j_next;
            scan_jd_reg  <= scan_jd_next;
            scan_vld_reg <= scan_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.find_take) begin
            cur_reg <= scan_jd_reg;
        end
        if (cmd.pop_take) begin
            cur_reg <= ring_rd;
        end
        if (cmd.exec) begin
            pid_reg   <= stat_rd[7:0];
            arr_reg   <= rd_arr;
            burst_reg <= stat_rd[39:24];
            start_reg <= clock_reg;
            fin_reg   <= (rem_new == '0);
        end
        if (cmd.finish) begin
            if (fin_reg && (clock_reg >= KW'(arr_reg))) begin
                turn_reg <= clock_reg - KW'(arr_reg);
            end else begin
                turn_reg <= '0;
            end
        end
        if (cmd.wait_calc) begin
            if (turn_reg >= KW'(burst_reg)) begin
                wait_reg <= turn_reg - KW'(burst_reg);
            end else begin
                wait_reg <= '0;
            end
        end
        if (cmd.emit) begin
            out_pid_reg   <= pid_reg;
            out_start_reg <= start_reg;
            out_end_reg   <= clock_reg;
            out_fin_reg   <= fin_reg;
            out_wait_reg  <= wait_reg;
            out_turn_reg  <= turn_reg;
            out_done_reg  <= 1'b0;
        end else if (cmd.emit_done) begin
            out_pid_reg   <= '0;
            out_start_reg <= '0;
            out_end_reg   <= '0;
            out_fin_reg   <= 1'b0;
            out_wait_reg  <= '0;
            out_turn_reg  <= '0;
            out_done_reg  <= 1'b1;
        end
    end

    assign status.ring_empty  = (fill_reg == '0);
    assign status.table_empty = (loaded_reg == '0);
    assign status.find_hit    = scan_vld_reg && (rem_rd != '0);
    assign status.scan_last   = scan_vld_reg && ((jd_ext + CW'(1)) == loaded_reg);
    assign status.out_free    = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_turn_reg, out_wait_reg, out_fin_reg,
                       out_end_reg, out_start_reg, out_pid_reg};
    assign m_tuser  = out_done_reg;

endmodule
`default_nettype wire

// ----- design/rrs_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_ctrl
// Sequencer for clear, load and dispatch transactions.
// ----------------------------------------------------------------------------
module rrs_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    input  wire logic [rrs_pkg::FUNC_W-1:0]   func,
    output logic                              in_ready,
    input  wire rrs_pkg::status_t             status,
    output rrs_pkg::cmd_t                     cmd
);
    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_FIND      = 11'b000_0000_0010,
        ST_POP       = 11'b000_0000_0100,
        ST_POP_TAKE  = 11'b000_0000_1000,
        ST_READ_CUR  = 11'b000_0001_0000,
        ST_EXEC      = 11'b000_0010_0000,
        ST_SCAN      = 11'b000_0100_0000,
        ST_FINISH    = 11'b000_1000_0000,
        ST_WAIT_CALC = 11'b001_0000_0000,
        ST_EMIT      = 11'b010_0000_0000,
        ST_EMIT_DONE = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    unique case (func)
                        rrs_pkg::FUNC_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        rrs_pkg::FUNC_LOAD: begin
                            cmd.load = 1'b1;
                        end
                        rrs_pkg::FUNC_DISPATCH: begin
                            if (!status.ring_empty) begin
                                state_next = ST_POP;
                            end else if (status.table_empty) begin
                                state_next = ST_EMIT_DONE;
                            end else begin
                                cmd.scan_start = 1'b1;
                                state_next     = ST_FIND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FIND: begin
                cmd.scan_step = 1'b1;
                if (status.find_hit) begin
                    cmd.find_take = 1'b1;
                    state_next    = ST_READ_CUR;
                end else if (status.scan_last) begin
                    state_next = ST_EMIT_DONE;
                end
            end
            ST_POP: begin
                cmd.pop    = 1'b1;
                state_next = ST_POP_TAKE;
            end
            ST_POP_TAKE: begin
                cmd.pop_take = 1'b1;
                state_next   = ST_READ_CUR;
            end
            ST_READ_CUR: begin
                cmd.read_cur = 1'b1;
                state_next   = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.exec       = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                cmd.scan_eval = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_WAIT_CALC;
            end
            ST_WAIT_CALC: begin
                cmd.wait_calc = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_DONE: begin
                if (status.out_free) begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire
